// File: design/bcu_pkg.sv
// Package for the binomial coefficient unit.
// Holds field widths, parameter defaults, the sequencer state type and the
// control struct for the serial cells. No dependencies.
package bcu_pkg;

    localparam int IN_W         = 6;
    localparam int COEF_W       = 59;
    localparam int MAX_N_DEF    = 62;
    localparam int RESULT_W_DEF = 64;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic en;
        logic first;
    } t_cell_ctl;

endpackage

// File: design/bcu_mul_cell.sv
// Bit-serial multiply of an LSB-first bit stream by a 6-bit factor.
// Keeps the running carry between bits. Uses bcu_pkg.
module bcu_mul_cell (
    input  logic                     i_clk,
    input  bcu_pkg::t_cell_ctl       i_ctl,
    input  logic                     i_bit,
    input  logic [bcu_pkg::IN_W-1:0] i_factor,
    output logic                     o_bit
);
    import bcu_pkg::*;

    logic [IN_W-1:0] r_carry;
    logic [IN_W-1:0] n_carry;
    logic [IN_W:0]   w_sum;

    always_comb begin
        w_sum   = (i_bit ? {1'b0, i_factor} : '0)
                + (i_ctl.first ? '0 : {1'b0, r_carry});
        o_bit   = w_sum[0];
        n_carry = w_sum[IN_W:1];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_carry <= n_carry;
        end
    end

endmodule

// File: design/bcu_div_cell.sv
// Bit-serial restoring divide of an MSB-first bit stream by a 6-bit divisor.
// Emits one quotient bit per cycle while enabled and keeps the partial remainder. Uses bcu_pkg.
module bcu_div_cell (
    input  logic                     i_clk,
    input  bcu_pkg::t_cell_ctl       i_ctl,
    input  logic                     i_bit,
    input  logic [bcu_pkg::IN_W-1:0] i_divisor,
    output logic                     o_bit
);
    import bcu_pkg::*;

    logic [IN_W-1:0] r_rem;
    logic [IN_W-1:0] n_rem;
    logic [IN_W:0]   w_cand;
    logic [IN_W:0]   w_diff;

    always_comb begin
        w_cand = {(i_ctl.first ? '0 : r_rem), i_bit};
        w_diff = w_cand - {1'b0, i_divisor};
        o_bit  = (w_cand >= {1'b0, i_divisor});
        n_rem  = o_bit ? w_diff[IN_W-1:0] : w_cand[IN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_rem <= n_rem;
        end
    end

endmodule

// File: design/binomial_coefficient_unit_core.sv
// Top level of the binomial coefficient unit: sequencer, accumulator shift
// register and output register. Uses bcu_pkg, bcu_mul_cell, bcu_div_cell.
//
//   channel  valid        ready        payload
//   input    i_in_valid   o_in_ready   i_n_total, i_k_chosen
//   output   o_out_valid  i_out_ready  o_coefficient, o_invalid
//
// With k' = min(k, n-k), a valid request with k' >= 2 runs k' loop steps; any
// other goes from idle straight to the final state; each loop step is one
// pass of the accumulator through the serial multiplier and one through the
// serial divider, one bit per cycle. Reset is synchronous and clears control
// state only. A new input is taken once the previous result sits in the output
// register; a stalled output holds the sequencer in its final state.
module binomial_coefficient_unit_core #(
    parameter int MAX_N        = bcu_pkg::MAX_N_DEF,
    parameter int RESULT_WIDTH = bcu_pkg::RESULT_W_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [bcu_pkg::IN_W-1:0]   i_n_total,
    input  logic [bcu_pkg::IN_W-1:0]   i_k_chosen,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [bcu_pkg::COEF_W-1:0] o_coefficient,
    output logic                       o_invalid
);
    import bcu_pkg::*;

    localparam int BW = (RESULT_WIDTH > 1) ? $clog2(RESULT_WIDTH) : 1;
    localparam logic [BW-1:0] LAST_BIT = BW'(RESULT_WIDTH - 1);

    t_state                  r_state, n_state;
    logic [RESULT_WIDTH-1:0] r_acc, n_acc;
    logic [IN_W-1:0]         r_n, r_k, r_i;
    logic [BW-1:0]           r_bit;
    logic                    r_inv;
    logic                    r_out_valid;
    logic [COEF_W-1:0]       r_out_coef;
    logic                    r_out_inv;

    t_cell_ctl               w_mul_ctl, w_div_ctl;
    logic                    w_mul_bit, w_div_bit;
    logic                    w_accept, w_load_out, w_last;
    logic                    w_bad;
    logic [IN_W-1:0]         w_k_red;
    logic [IN_W-1:0]         w_factor;
    logic [COEF_W-1:0]       w_coef;

    bcu_mul_cell u_mul (
        .i_clk    (i_clk),
        .i_ctl    (w_mul_ctl),
        .i_bit    (r_acc[0]),
        .i_factor (w_factor),
        .o_bit    (w_mul_bit)
    );

    bcu_div_cell u_div (
        .i_clk     (i_clk),
        .i_ctl     (w_div_ctl),
        .i_bit     (r_acc[RESULT_WIDTH-1]),
        .i_divisor (r_i),
        .o_bit     (w_div_bit)
    );

    generate
        if (RESULT_WIDTH >= COEF_W) begin : g_trunc
            assign w_coef = r_acc[COEF_W-1:0];
        end else begin : g_ext
            assign w_coef = {{(COEF_W - RESULT_WIDTH){1'b0}}, r_acc};
        end
    endgenerate

    always_comb begin
        w_bad    = (i_k_chosen > i_n_total) || (i_n_total > IN_W'(MAX_N));
        w_k_red  = (i_k_chosen > (i_n_total >> 1)) ? (i_n_total - i_k_chosen) : i_k_chosen;
        w_factor = r_n - r_k + r_i;
        w_last   = (r_bit == LAST_BIT);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (w_bad || w_k_red < IN_W'(2)) ? S_FIN : S_MUL;
                end
            end
            S_MUL: begin
                if (w_last) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_last) begin
                    n_state = (r_i == r_k) ? S_FIN : S_MUL;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_ready = 1'b0;
        w_load_out = 1'b0;
        w_mul_ctl  = '0;
        w_div_ctl  = '0;
        n_acc      = r_acc;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (w_bad) begin
                    n_acc = '0;
                end else if (w_k_red == '0) begin
                    n_acc = RESULT_WIDTH'(1);
                end else if (w_k_red == IN_W'(1)) begin
                    n_acc = RESULT_WIDTH'(i_n_total);
                end else begin
                    n_acc = RESULT_WIDTH'(1);
                end
            end
            S_MUL: begin
                w_mul_ctl.en    = 1'b1;
                w_mul_ctl.first = (r_bit == '0);
                n_acc = {w_mul_bit, r_acc[RESULT_WIDTH-1:1]};
            end
            S_DIV: begin
                w_div_ctl.en    = 1'b1;
                w_div_ctl.first = (r_bit == '0);
                n_acc = {r_acc[RESULT_WIDTH-2:0], w_div_bit};
            end
            S_FIN: begin
                w_load_out = !r_out_valid || i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_bit       <= '0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_MUL || r_state == S_DIV) begin
                r_bit <= w_last ? '0 : r_bit + BW'(1);
            end else begin
                r_bit <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state != S_FIN) begin
            r_acc <= n_acc;
        end
        if (w_accept) begin
            r_n   <= i_n_total;
            r_k   <= w_k_red;
            r_i   <= IN_W'(1);
            r_inv <= w_bad;
        end else if (r_state == S_DIV && w_last) begin
            r_i <= r_i + IN_W'(1);
        end
        if (w_load_out) begin
            r_out_coef <= w_coef;
            r_out_inv  <= r_inv;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_coefficient = r_out_coef;
    assign o_invalid     = r_out_inv;

endmodule

// File: design/bcu_checker.sv
// Port-level checker for binomial_coefficient_unit_core, bound to the top level.
// Uses bcu_pkg for field widths.
module bcu_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic [bcu_pkg::IN_W-1:0]   i_n_total,
    input logic [bcu_pkg::IN_W-1:0]   i_k_chosen,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [bcu_pkg::COEF_W-1:0] o_coefficient,
    input logic                       o_invalid
);
    import bcu_pkg::*;

    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_invalid |-> o_coefficient == '0)
        else $error("invalid result with nonzero coefficient");

    a_valid_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_invalid |-> o_coefficient != '0)
        else $error("valid result with zero coefficient");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after a transaction");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_coefficient)
            && $stable(o_invalid))
        else $error("stalled output changed");

endmodule

bind binomial_coefficient_unit_core bcu_checker u_bcu_checker (.*);

// File: sim/tb_binomial_coefficient_unit_core.sv
// Testbench for binomial_coefficient_unit_core: a queue-fed driver, an output
// monitor with its own binomial predictor, and phased idle/stall pressure.
// Depends on bcu_pkg and the design under design/.
module tb_binomial_coefficient_unit_core;

    import bcu_pkg::*;

    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int HOLD_CYCLES = 10000;

    typedef struct packed {
        logic [IN_W-1:0] n;
        logic [IN_W-1:0] k;
    } binom_req_t;

    typedef struct packed {
        logic [COEF_W-1:0] coef;
        logic              invalid;
    } binom_res_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [IN_W-1:0]   i_n_total = '0;
    logic [IN_W-1:0]   i_k_chosen = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [COEF_W-1:0] o_coefficient;
    logic              o_invalid;

    binom_req_t pending_req_q[$];
    binom_res_t expected_res_q[$];
    binom_req_t next_req;
    binom_res_t want;

    int  src_idle_pct = 0;
    int  snk_stall_pct = 0;
    int  pushed_total = 0;
    int  accepted_total = 0;
    int  results_total = 0;
    int  invalid_total = 0;
    int  error_count = 0;
    int  cycle_count = 0;
    int  hold_requests = 0;
    int  hold_served = 0;
    int  hold_left = 0;
    logic in_fire_q = 1'b0;

    binomial_coefficient_unit_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_n_total     (i_n_total),
        .i_k_chosen    (i_k_chosen),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_coefficient (o_coefficient),
        .o_invalid     (o_invalid)
    );

    function automatic binom_res_t calc_binomial(logic [IN_W-1:0] n, logic [IN_W-1:0] k);
        binom_res_t      res;
        longint unsigned prod;
        int              kk;
        res = '0;
        if (k > n || n > MAX_N_DEF) begin
            res.invalid = 1'b1;
            return res;
        end
        kk = int'(k);
        if (kk > n / 2)
            kk = n - kk;
        prod = 1;
        for (int i = 1; i <= kk; i++) begin
            prod = prod * longint'(n - kk + i);
            prod = prod / longint'(i);
        end
        res.coef = prod[COEF_W-1:0];
        return res;
    endfunction

    function automatic binom_req_t rand_request();
        binom_req_t r;
        int         pick;
        int         n;
        int         kp;
        pick = $urandom_range(99);
        n = $urandom_range(62);
        if (pick < 8) begin
            r.n = IN_W'(n);
            r.k = IN_W'($urandom_range(63, n + 1));
        end else if (pick < 12) begin
            r.n = IN_W'(63);
            r.k = IN_W'($urandom_range(63));
        end else if (pick < 20) begin
            r.n = IN_W'(n);
            r.k = IN_W'($urandom_range(n));
        end else begin
            kp = $urandom_range((n / 2 < 4) ? n / 2 : 4);
            r.n = IN_W'(n);
            r.k = $urandom_range(1) ? IN_W'(kp) : IN_W'(n - kp);
        end
        return r;
    endfunction

    task automatic push_req(int n, int k);
        binom_req_t r;
        r.n = IN_W'(n);
        r.k = IN_W'(k);
        pending_req_q.push_back(r);
        pushed_total++;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (accepted_total != pushed_total || results_total != accepted_total);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("binomial_coefficient_unit_core verification failed");
            $finish;
        end
    end

    // input driver
    always @(negedge i_clk) begin
        if (!i_in_valid || in_fire_q) begin
            if (i_rst_n && pending_req_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                next_req = pending_req_q.pop_front();
                i_in_valid <= 1'b1;
                i_n_total  <= next_req.n;
                i_k_chosen <= next_req.k;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output ready, with long hold-off on request
    always @(negedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= i_rst_n && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // monitor: check results first, then record newly accepted requests
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_total++;
            if (expected_res_q.size() == 0) begin
                $error("result with no pending request: coefficient %0d invalid %0b",
                       o_coefficient, o_invalid);
                error_count++;
            end else begin
                want = expected_res_q.pop_front();
                if (o_coefficient !== want.coef) begin
                    $error("coefficient: expected %0d, got %0d", want.coef, o_coefficient);
                    error_count++;
                end
                if (o_invalid !== want.invalid) begin
                    $error("invalid: expected %0b, got %0b", want.invalid, o_invalid);
                    error_count++;
                end
                if (want.invalid)
                    invalid_total++;
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            accepted_total++;
            expected_res_q.push_back(calc_binomial(i_n_total, i_k_chosen));
        end
        in_fire_q <= i_rst_n && i_in_valid && o_in_ready;
    end

    initial begin
        int idle_tab[4];
        int stall_tab[4];
        binom_req_t gen_req;
        idle_tab  = '{0, 70, 0, 37};
        stall_tab = '{0, 0, 70, 37};
        i_rst_n     = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        push_req(0, 0);
        push_req(63, 0);
        push_req(63, 63);
        push_req(0, 63);
        push_req(63, 31);
        push_req(62, 31);
        push_req(62, 32);
        push_req(62, 30);
        push_req(62, 0);
        push_req(62, 62);
        push_req(62, 1);
        push_req(62, 61);
        push_req(1, 0);
        push_req(1, 1);
        push_req(1, 2);
        push_req(5, 6);
        push_req(2, 1);
        push_req(4, 2);
        push_req(10, 3);
        push_req(10, 7);
        push_req(40, 20);
        push_req(33, 16);
        push_req(61, 30);
        push_req(20, 10);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            @(posedge i_clk);
            src_idle_pct  = idle_tab[ph];
            snk_stall_pct = stall_tab[ph];
            for (int j = 0; j < 60; j++) begin
                gen_req = rand_request();
                push_req(int'(gen_req.n), int'(gen_req.k));
            end
            wait_drained();
        end

        // receiver holds off while the sender keeps offering
        @(posedge i_clk);
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_requests++;
        for (int j = 0; j < 40; j++) begin
            gen_req = rand_request();
            push_req(int'(gen_req.n), int'(gen_req.k));
        end
        wait_drained();

        repeat (20) @(posedge i_clk);
        $display("checked %0d transactions (%0d invalid requests) over %0d cycles,",
                 results_total, invalid_total, cycle_count);
        $display("phases: no idling, sender idle, receiver stall, both, long hold-off");
        if (error_count == 0 && expected_res_q.size() == 0) begin
            $display("binomial_coefficient_unit_core verification clean");
        end else begin
            $display("binomial_coefficient_unit_core verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/bcu_pkg.sv
design/bcu_mul_cell.sv
design/bcu_div_cell.sv
design/binomial_coefficient_unit_core.sv
design/bcu_checker.sv
sim/tb_binomial_coefficient_unit_core.sv
